// File: rtl/rat_pkg.sv
`default_nettype none

package rat_pkg;

  // field widths of one event
  localparam int UNIT_BITS   = 8;
  localparam int AMOUNT_BITS = 24;
  localparam int PLAYER_BITS = 5;
  localparam int OBJECT_BITS = 13;
  localparam int TICK_BITS   = 32;

  // word layouts on the two streams
  localparam int IN_DATA_BITS  = 88;
  localparam int OUT_DATA_BITS = 8;
  localparam int MASK_BITS     = 4;
  localparam int FILL_BITS     = 2;

  localparam logic [AMOUNT_BITS-1:0] DAMAGE_MAX  = '1;
  localparam logic [PLAYER_BITS-1:0] PLAYER_NONE = '1;

  // one attacker slot as stored in a table row
  typedef struct packed {
    logic                   valid;
    logic [PLAYER_BITS-1:0] player;
    logic [OBJECT_BITS-1:0] object;
    logic [AMOUNT_BITS-1:0] damage;
    logic [TICK_BITS-1:0]   stamp;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MATCH,
    ST_WRITE
  } rat_state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic eval;
    logic commit;
  } rat_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } rat_status_t;

endpackage

`default_nettype wire

// File: rtl/recent_attacker_table.sv
`default_nettype none
// Recent attacker table: each victim unit keeps SLOTS attacker slots that
// accumulate saturating Q16.8 damage and a time stamp per attacker.
// Input stream (s_*): one word per damage event. Output stream (m_*): one
// word per event with the match mask, the slot filled on a miss and a flag
// telling whether a valid slot was evicted. An event for a unit at or
// beyond UNITS changes nothing and yields an all-zero result.
// Each event passes these steps: the accept cycle issues the row read from the
// table memory, then a match and accumulate cycle, then a cycle that picks
// the eviction slot, writes the row back and loads the result register.
// The next event may be taken in the cycle right after the write-back and
// not before; the single read/write of a unit row keeps the block from
// taking a new event before it is through with the last one.
// The result sits in an output register; a new event may be accepted while
// it waits. If the receiver stalls, the following event holds in its final
// cycle until the register frees.
// After reset the table is cleared one unit row a cycle, all UNITS rows in
// turn, with s_tready low.
module recent_attacker_table #(
  parameter int SLOTS = 4,
  parameter int UNITS = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // victim_unit, hit_amount, attacker_player, attacker_object, now_tick
  input  wire logic [rat_pkg::IN_DATA_BITS-1:0]    s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // match_mask, fill_slot, fill_replaced
  output logic      [rat_pkg::OUT_DATA_BITS-1:0]   m_tdata
);

  import rat_pkg::*;

  rat_cmd_t    cmd;
  rat_status_t status;

  rat_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  rat_dp #(
    .SLOTS(SLOTS),
    .UNITS(UNITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (s_tdata),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (m_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/rat_ram.sv
`default_nettype none

module rat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/rat_ctrl.sv
`default_nettype none

module rat_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rat_pkg::rat_status_t status,
  output rat_pkg::rat_cmd_t         cmd
);

  import rat_pkg::*;

  rat_state_t state;
  rat_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.eval   = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rat_dp.sv
`default_nettype none

module rat_dp #(
  parameter int SLOTS = 4,
  parameter int UNITS = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire rat_pkg::rat_cmd_t                   cmd,
  output rat_pkg::rat_status_t                     status,
  input  wire logic [rat_pkg::IN_DATA_BITS-1:0]    in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [rat_pkg::OUT_DATA_BITS-1:0]   out_data
);

  import rat_pkg::*;

  localparam int UNIT_W = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int ROW_W  = SLOTS * SLOT_BITS;

  // input word fields
  logic [UNIT_BITS-1:0]   f_unit;
  logic [AMOUNT_BITS-1:0] f_amount;
  logic [PLAYER_BITS-1:0] f_player;
  logic [OBJECT_BITS-1:0] f_object;
  logic [TICK_BITS-1:0]   f_tick;

  assign f_unit   = in_data[7:0];
  assign f_amount = in_data[31:8];
  assign f_player = in_data[36:32];
  assign f_object = in_data[49:37];
  assign f_tick   = in_data[81:50];

  // captured event
  logic [UNIT_W-1:0]      ev_unit;
  logic                   ev_in_range;
  logic [AMOUNT_BITS-1:0] ev_amount;
  logic [PLAYER_BITS-1:0] ev_player;
  logic [OBJECT_BITS-1:0] ev_object;
  logic [TICK_BITS-1:0]   ev_tick;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ev_unit     <= UNIT_W'(f_unit);
      ev_in_range <= 32'(f_unit) < 32'(UNITS);
      ev_amount   <= f_amount;
      ev_player   <= f_player;
      ev_object   <= f_object;
      ev_tick     <= f_tick;
    end
  end

  // clearing pass counter
  logic [UNIT_W-1:0] clear_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
    end else if (cmd.clear_wr) begin
      clear_cnt <= clear_cnt + UNIT_W'(1);
    end
  end

  assign status.clear_last = (clear_cnt == UNIT_W'(UNITS - 1));

  // table memory, one row of slots per unit
  logic              ram_wr_en;
  logic [UNIT_W-1:0] ram_wr_addr;
  logic [ROW_W-1:0]  ram_wr_data;
  logic [ROW_W-1:0]  ram_rd_data;
  logic [ROW_W-1:0]  row_new_flat;

  rat_ram #(
    .WIDTH(ROW_W),
    .DEPTH(UNITS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (cmd.load),
    .rd_addr(UNIT_W'(f_unit)),
    .rd_data(ram_rd_data)
  );

  assign ram_wr_en   = cmd.clear_wr || (cmd.commit && ev_in_range);
  assign ram_wr_addr = cmd.clear_wr ? clear_cnt : ev_unit;
  assign ram_wr_data = cmd.clear_wr ? '0 : row_new_flat;

  // match stage: compare, accumulate, find free slot and top damage
  slot_t            rd_slot  [SLOTS];
  slot_t            acc_slot [SLOTS];
  logic [SLOTS-1:0] match_c;
  logic             any_free_c;
  logic [IDX_W-1:0] free_c;
  logic [IDX_W-1:0] best_c;
  logic [AMOUNT_BITS:0] sum_c [SLOTS];

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      rd_slot[i]  = ram_rd_data[i*SLOT_BITS +: SLOT_BITS];
      match_c[i]  = rd_slot[i].valid &&
                    (((ev_player != PLAYER_NONE) && (rd_slot[i].player == ev_player)) ||
                     (rd_slot[i].object == ev_object));
      sum_c[i]    = {1'b0, rd_slot[i].damage} + {1'b0, ev_amount};
      acc_slot[i] = rd_slot[i];
      if (match_c[i]) begin
        acc_slot[i].damage = sum_c[i][AMOUNT_BITS] ? DAMAGE_MAX : sum_c[i][AMOUNT_BITS-1:0];
        acc_slot[i].stamp  = ev_tick;
      end
    end
    // lowest free slot
    any_free_c = 1'b0;
    free_c     = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!rd_slot[i].valid) begin
        any_free_c = 1'b1;
        free_c     = IDX_W'(i);
      end
    end
    // lowest-indexed slot of highest damage
    best_c = '0;
    for (int i = 1; i < SLOTS; i++) begin
      if (rd_slot[i].damage > rd_slot[best_c].damage) begin
        best_c = IDX_W'(i);
      end
    end
  end

  slot_t            row_q [SLOTS];
  logic [SLOTS-1:0] match_q;
  logic             any_free_q;
  logic [IDX_W-1:0] free_q;
  logic [IDX_W-1:0] best_q;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      row_q      <= acc_slot;
      match_q    <= match_c;
      any_free_q <= any_free_c;
      free_q     <= free_c;
      best_q     <= best_c;
    end
  end

  // write stage: pick the victim slot on a miss and build the new row
  logic             hit;
  logic             old_found;
  logic [IDX_W-1:0] oldest;
  logic [IDX_W-1:0] target;
  slot_t            row_new [SLOTS];
  slot_t            fresh;

  assign hit = |match_q;

  always_comb begin
    old_found = 1'b0;
    oldest    = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (IDX_W'(i) != best_q) begin
        if (!old_found || (row_q[i].stamp < row_q[oldest].stamp)) begin
          oldest    = IDX_W'(i);
          old_found = 1'b1;
        end
      end
    end
    target = any_free_q ? free_q : oldest;

    fresh.valid  = 1'b1;
    fresh.player = ev_player;
    fresh.object = ev_object;
    fresh.damage = ev_amount;
    fresh.stamp  = ev_tick;

    for (int i = 0; i < SLOTS; i++) begin
      row_new[i] = row_q[i];
      if (!hit && (IDX_W'(i) == target)) begin
        row_new[i] = fresh;
      end
      row_new_flat[i*SLOT_BITS +: SLOT_BITS] = row_new[i];
    end
  end

  // result word
  logic [SLOTS+MASK_BITS-1:0] mask_ext;
  logic [IDX_W+FILL_BITS-1:0] fill_ext;
  logic [MASK_BITS-1:0]       res_mask;
  logic [FILL_BITS-1:0]       res_fill;
  logic                       res_repl;

  always_comb begin
    mask_ext = {{MASK_BITS{1'b0}}, match_q};
    fill_ext = {{FILL_BITS{1'b0}}, target};
    res_mask = '0;
    res_fill = '0;
    res_repl = 1'b0;
    if (ev_in_range) begin
      res_mask = mask_ext[MASK_BITS-1:0];
      if (!hit) begin
        res_fill = fill_ext[FILL_BITS-1:0];
        res_repl = !any_free_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {1'b0, res_repl, res_fill, res_mask};
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire
